FILE: design/gbs_pkg.sv
// Package for greedy box suppression: sizing constants and register reset value.
// No dependencies.
package gbs_pkg;
  localparam int unsigned MaxBoxesDef  = 64;
  localparam int unsigned CoordBitsDef = 12;
  localparam logic [15:0] LimitReset  = 16'd32768;
endpackage

FILE: design/gbs_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module gbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/gbs_iou_unit.sv
// Shared overlap test: pipelined IoU compare of two boxes with a registered hit.
// Depends on gbs_pkg.
module gbs_iou_unit
  import gbs_pkg::*;
#(
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic signed [CoordBits-1:0] al_i, at_i, ar_i, ab_i,
  input  logic signed [CoordBits-1:0] bl_i, bt_i, br_i, bb_i,
  input  logic [15:0]                 limit_i,
  output logic                        hit_o
);
  localparam int unsigned DW = CoordBits + 1;
  localparam int unsigned AW = 2 * DW;
  localparam int unsigned UW = AW + 2;
  localparam int unsigned PW = UW + 17;

  logic signed [DW-1:0] awd_q, ahd_q, bwd_q, bhd_q, iw_q, ih_q;
  logic signed [AW-1:0] aa_q, ba_q, ia_q;
  logic signed [UW-1:0] un_q;
  logic signed [UW-1:0] ia2_q;
  logic signed [PW-1:0] lhs_q, rhs_q;
  logic                 upos_q;
  logic                 upos_dly_q;
  logic signed [DW-1:0] iw_d, ih_d;
  logic signed [CoordBits-1:0] mnr, mxl, mnb, mxt;

  always_comb begin
    mnr  = (ar_i < br_i) ? ar_i : br_i;
    mxl  = (al_i > bl_i) ? al_i : bl_i;
    mnb  = (ab_i < bb_i) ? ab_i : bb_i;
    mxt  = (at_i > bt_i) ? at_i : bt_i;
    iw_d = DW'(mnr) - DW'(mxl);
    ih_d = DW'(mnb) - DW'(mxt);
    if (iw_d < 0) iw_d = '0;
    if (ih_d < 0) ih_d = '0;
  end

  always_ff @(posedge clk_i) begin
    awd_q <= DW'(ar_i) - DW'(al_i);
    ahd_q <= DW'(ab_i) - DW'(at_i);
    bwd_q <= DW'(br_i) - DW'(bl_i);
    bhd_q <= DW'(bb_i) - DW'(bt_i);
    iw_q  <= iw_d;
    ih_q  <= ih_d;
    aa_q  <= AW'(awd_q) * AW'(ahd_q);
    ba_q  <= AW'(bwd_q) * AW'(bhd_q);
    ia_q  <= AW'(iw_q) * AW'(ih_q);
    un_q  <= UW'(aa_q) + UW'(ba_q) - UW'(ia_q);
    ia2_q <= UW'(ia_q);
    upos_q <= (UW'(aa_q) + UW'(ba_q) - UW'(ia_q)) > 0;
    lhs_q <= PW'(ia2_q) <<< 16;
    rhs_q <= PW'($signed({1'b0, limit_i})) * PW'(un_q);
    upos_dly_q <= upos_q;
    hit_o <= upos_dly_q && (lhs_q > rhs_q);
  end
endmodule

FILE: design/greedy_box_suppression_core.sv
// Top level of greedy box suppression: box store, order list, sequencer, output register.
// Depends on gbs_pkg, gbs_ram, gbs_iou_unit.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------
//  box in    | in_valid/stall   | x_left y_top x_right y_bottom score last_box
//  kept out  | out_valid/stall  | kept_* final_kept overflowed
//  config    | cfg_we_i         | cfg_data_i (overlap limit)
//
// A request that is not last is stored with no stall. A last box starts
// ranking: pass i of the stable insertion compares at most i neighbors.
// Suppression then visits each rank position: a suppressed head is skipped,
// else the kept box is fetched, each later suppressed box is skipped, each
// later unmarked box gets an IoU test that marks it on a hit, then the kept
// box is emitted. Input stalls meanwhile.
// Reset clears control, count and flags; a stalled full output register
// holds the sequencer in the emit step.
module greedy_box_suppression_core
  import gbs_pkg::*;
#(
  parameter int unsigned MaxBoxes  = MaxBoxesDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CoordBits-1:0] x_left_i,
  input  logic [CoordBits-1:0] y_top_i,
  input  logic [CoordBits-1:0] x_right_i,
  input  logic [CoordBits-1:0] y_bottom_i,
  input  logic [15:0]          score_i,
  input  logic                 last_box_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CoordBits-1:0] kept_left_o,
  output logic [CoordBits-1:0] kept_top_o,
  output logic [CoordBits-1:0] kept_right_o,
  output logic [CoordBits-1:0] kept_bottom_o,
  output logic [15:0]          kept_score_o,
  output logic                 final_kept_o,
  output logic                 overflowed_o
);
  localparam int unsigned IW = $clog2(MaxBoxes);
  localparam int unsigned CW = $clog2(MaxBoxes + 1);
  localparam int unsigned BW = 4 * CoordBits + 16;
  localparam int unsigned Lat = 5;
  localparam int unsigned LW = 3;

  typedef enum logic [13:0] {
    S_LOAD  = 14'b00000000000001,
    S_SRD   = 14'b00000000000010,
    S_SCUR  = 14'b00000000000100,
    S_ORD   = 14'b00000000001000,
    S_OWAIT = 14'b00000000010000,
    S_SCMP  = 14'b00000000100000,
    S_SPUT  = 14'b00000001000000,
    S_ARD   = 14'b00000010000000,
    S_AORD  = 14'b00000100000000,
    S_ABOX  = 14'b00001000000000,
    S_BRD   = 14'b00010000000000,
    S_BORD  = 14'b00100000000000,
    S_BWAIT = 14'b01000000000000,
    S_EMIT  = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic [15:0]   limit_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, surv_q, surv_d;
  logic [15:0]   cur_s_q, cur_s_d;
  logic [IW-1:0] prev_q, prev_d;
  logic [BW-1:0] abox_q, abox_d;
  logic [LW-1:0] wait_q, wait_d;
  logic          ov_q, ov_d;
  logic [BW-1:0] obox_q, obox_d;
  logic          ofin_q, ofin_d, oovf_q, oovf_d;

  logic          in_take;
  logic          st_we;
  logic [IW-1:0] st_waddr, st_raddr;
  logic [BW-1:0] st_rdata;
  logic          ord_we;
  logic [IW-1:0] ord_waddr, ord_raddr;
  logic [IW:0]   ord_wdata, ord_rdata;
  logic          hit;

  // box store: {left, top, right, bottom, score}, one word per arrival slot
  gbs_ram #(.Width(BW), .Depth(MaxBoxes)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr),
    .wdata_i({x_left_i, y_top_i, x_right_i, y_bottom_i, score_i}),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  // order list: {suppressed mark, box slot} per rank position; the ranking
  // rewrites every position of the set, which also clears the marks
  gbs_ram #(.Width(IW + 1), .Depth(MaxBoxes)) u_order (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  gbs_iou_unit #(.CoordBits(CoordBits)) u_iou (
    .clk_i,
    .al_i(abox_q[BW-1 -: CoordBits]), .at_i(abox_q[BW-1-CoordBits -: CoordBits]),
    .ar_i(abox_q[BW-1-2*CoordBits -: CoordBits]), .ab_i(abox_q[16 +: CoordBits]),
    .bl_i(st_rdata[BW-1 -: CoordBits]), .bt_i(st_rdata[BW-1-CoordBits -: CoordBits]),
    .br_i(st_rdata[BW-1-2*CoordBits -: CoordBits]), .bb_i(st_rdata[16 +: CoordBits]),
    .limit_i(limit_q), .hit_o(hit)
  );

  // accept requests only while loading; a full store drops the box
  assign in_stall_o = (state_q != S_LOAD);
  assign in_take    = in_valid_i && !in_stall_o;
  assign st_we      = in_take && (cnt_q < CW'(MaxBoxes));
  assign st_waddr   = cnt_q[IW-1:0];

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ovf_d = ovf_q; i_d = i_q; j_d = j_q;
    surv_d = surv_q; cur_s_d = cur_s_q; prev_d = prev_q; abox_d = abox_q;
    wait_d = wait_q; obox_d = obox_q; ofin_d = ofin_q; oovf_d = oovf_q;
    // drop the output word once it is taken
    ov_d = ov_q && out_stall_i;
    st_raddr  = prev_q;
    ord_raddr = j_q[IW-1:0];
    ord_we    = 1'b0;
    ord_waddr = j_q[IW-1:0];
    ord_wdata = {1'b0, prev_q};
    unique case (state_q)
      S_LOAD: begin
        if (in_take) begin
          if (cnt_q < CW'(MaxBoxes)) cnt_d = cnt_q + CW'(1);
          else ovf_d = 1'b1;
          if (last_box_i) begin
            i_d = '0;
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        // fetch the score of the box being inserted
        st_raddr = i_q[IW-1:0];
        j_d = i_q;
        state_d = S_SCUR;
      end
      S_SCUR: begin
        cur_s_d = st_rdata[15:0];
        state_d = (j_q == '0) ? S_SPUT : S_ORD;
      end
      S_ORD: begin
        ord_raddr = j_q[IW-1:0] - IW'(1);
        state_d = S_OWAIT;
      end
      S_OWAIT: begin
        // neighbor slot arrives; fetch its score
        prev_d   = ord_rdata[IW-1:0];
        st_raddr = ord_rdata[IW-1:0];
        state_d  = S_SCMP;
      end
      S_SCMP: begin
        // move the lower-scored neighbor one place back; equal scores stay ahead
        if (st_rdata[15:0] < cur_s_q) begin
          ord_we = 1'b1;
          j_d = j_q - CW'(1);
          state_d = (j_q == CW'(1)) ? S_SPUT : S_ORD;
        end else begin
          state_d = S_SPUT;
        end
      end
      S_SPUT: begin
        ord_we    = 1'b1;
        ord_wdata = {1'b0, i_q[IW-1:0]};
        if (i_q + CW'(1) == cnt_q) begin
          i_d = '0; state_d = S_ARD;
        end else begin
          i_d = i_q + CW'(1); state_d = S_SRD;
        end
      end
      S_ARD: begin
        ord_raddr = i_q[IW-1:0];
        state_d = S_AORD;
      end
      S_AORD: begin
        // skip a suppressed head, else fetch the kept box
        if (ord_rdata[IW]) begin
          i_d = i_q + CW'(1); state_d = S_ARD;
        end else begin
          st_raddr = ord_rdata[IW-1:0];
          j_d = i_q + CW'(1); surv_d = '0; state_d = S_ABOX;
        end
      end
      S_ABOX: begin
        abox_d = st_rdata; state_d = S_BRD;
      end
      S_BRD: begin
        if (j_q == cnt_q) state_d = S_EMIT;
        else state_d = S_BORD;
      end
      S_BORD: begin
        if (ord_rdata[IW]) begin
          j_d = j_q + CW'(1); state_d = S_BRD;
        end else begin
          prev_d   = ord_rdata[IW-1:0];
          st_raddr = ord_rdata[IW-1:0];
          wait_d = '0; state_d = S_BWAIT;
        end
      end
      S_BWAIT: begin
        // hold until the IoU result for this pair comes out of the pipeline
        if (wait_q == LW'(Lat)) begin
          if (hit) begin
            ord_we = 1'b1; ord_wdata = {1'b1, prev_q};
          end else begin
            surv_d = surv_q + CW'(1);
          end
          j_d = j_q + CW'(1); state_d = S_BRD;
        end else begin
          wait_d = wait_q + LW'(1);
        end
      end
      S_EMIT: begin
        // hold the kept box until the output register frees up; it is the
        // last one of the set when no later box survived its pass
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1; obox_d = abox_q; oovf_d = ovf_q;
          ofin_d = (surv_q == '0);
          if (surv_q == '0) begin
            cnt_d = '0; ovf_d = 1'b0; state_d = S_LOAD;
          end else begin
            i_d = i_q + CW'(1); state_d = S_ARD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  assign out_valid_o = ov_q;
  assign {kept_left_o, kept_top_o, kept_right_o, kept_bottom_o, kept_score_o} = obox_q;
  assign final_kept_o = ofin_q;
  assign overflowed_o = oovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD; limit_q <= LimitReset; cnt_q <= '0; ovf_q <= 1'b0;
      i_q <= '0; j_q <= '0; surv_q <= '0; wait_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; i_q <= i_d; j_q <= j_d;
      surv_q <= surv_d; wait_q <= wait_d; ov_q <= ov_d;
      if (cfg_we_i) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_s_q <= cur_s_d; prev_q <= prev_d; abox_q <= abox_d;
    obox_q <= obox_d; ofin_q <= ofin_d; oovf_q <= oovf_d;
  end
endmodule
